@@ hw/rtl/signed_int_to_decimal_text_core_macros.svh @@
// Assertion macros for the file that checks its own logic.
`ifndef SIGNED_INT_TO_DECIMAL_TEXT_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_TEXT_CORE_MACROS_SVH

`ifndef SYNTH
`define SIDT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define SIDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define SIDT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SIDT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/sidt_pkg.sv @@
`timescale 1ns / 1ps

package sidt_pkg;

    localparam int VALUE_BITS = 32;
    // Decimal digits needed for the largest magnitude; 1233/4096 approximates log10(2).
    localparam int DIGITS     = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int IDX_W      = $clog2(DIGITS);
    localparam int CNT_W      = $clog2(VALUE_BITS);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cvt_sts;

endpackage

@@ hw/rtl/sidt_bcd_unit.sv @@
`timescale 1ns / 1ps

module sidt_bcd_unit
    import sidt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_mag,
    output t_cvt_sts              o_sts,
    output logic [BCD_W-1:0]      o_bcd
);

    logic                  r_busy;
    logic                  n_busy;
    logic                  r_done;
    logic                  n_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic [VALUE_BITS-1:0] r_bin;
    logic [VALUE_BITS-1:0] n_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      n_bcd;
    logic [BCD_W-1:0]      w_adj;

    // Shift-and-add-three: every digit of five or more is corrected before the shift.
    always_comb begin
        for (int d = 0; d < DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                w_adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_bin  = i_mag;
            n_bcd  = '0;
        end else if (r_busy) begin
            n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
            n_bcd = {w_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_bcd      = r_bcd;

endmodule

@@ hw/rtl/signed_int_to_decimal_text_core.sv @@
// An accepted value runs through the 32 bit-serial steps of the BCD shift-and-add unit;
// its done strobe then moves the sequencer from S_CONV to S_EMIT, where the characters
// (1 to 11 per value) are registered. The input is not ready again until the last is.
// Characters leave at one per cycle while the output side is ready.
// Reset: synchronous, active low; the sequencer returns to idle and no output is valid.
`timescale 1ns / 1ps
`include "signed_int_to_decimal_text_core_macros.svh"

module signed_int_to_decimal_text_core
    import sidt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [VALUE_BITS-1:0] i_s_axis_tdata,  // value
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [7:0]            o_m_axis_tdata,  // character
    output logic                  o_m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic                  r_neg;
    logic                  n_neg;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      n_idx;
    logic                  r_tvalid;
    logic                  n_tvalid;
    logic [7:0]            r_char;
    logic [7:0]            n_char;
    logic                  r_last;
    logic                  n_last;

    logic                  w_accept;
    logic                  w_out_free;
    logic [VALUE_BITS-1:0] w_mag;
    t_cvt_sts              w_sts;
    logic [BCD_W-1:0]      w_bcd;
    logic [IDX_W-1:0]      w_top_idx;
    logic [3:0]            w_digit;
    logic                  w_char_digit;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_tvalid || i_m_axis_tready;
    assign w_mag           = i_s_axis_tdata[VALUE_BITS-1] ? (~i_s_axis_tdata + 1'b1)
                                                          : i_s_axis_tdata;

    sidt_bcd_unit u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_mag   (w_mag),
        .o_sts   (w_sts),
        .o_bcd   (w_bcd)
    );

    // The highest non-zero digit opens the digits after any minus sign; zero keeps its single digit.
    always_comb begin
        w_top_idx = '0;
        for (int d = 0; d < DIGITS; d++) begin
            if (w_bcd[4*d +: 4] != 4'd0) begin
                w_top_idx = IDX_W'(d);
            end
        end
    end

    assign w_digit = w_bcd[{r_idx, 2'b00} +: 4];

    always_comb begin
        n_state  = r_state;
        n_neg    = r_neg;
        n_idx    = r_idx;
        n_tvalid = r_tvalid && !i_m_axis_tready;
        n_char   = r_char;
        n_last   = r_last;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_neg   = i_s_axis_tdata[VALUE_BITS-1];
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (w_sts.done) begin
                    n_idx   = w_top_idx;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_tvalid = 1'b1;
                    if (r_neg) begin
                        n_char = CHAR_MINUS;
                        n_last = 1'b0;
                        n_neg  = 1'b0;
                    end else begin
                        n_char = CHAR_ZERO + {4'h0, w_digit};
                        n_last = (r_idx == '0);
                        if (r_idx == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            n_idx = r_idx - 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_neg    <= 1'b0;
            r_tvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_neg    <= n_neg;
            r_tvalid <= n_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_m_axis_tvalid = r_tvalid;
    assign o_m_axis_tdata  = r_char;
    assign o_m_axis_tlast  = r_last;

    assign w_char_digit = (r_char >= CHAR_ZERO) && (r_char <= CHAR_NINE);

    `SIDT_ASSERT_SAME(a_ready_unit_idle, i_clk, i_rst_n, o_s_axis_tready, !w_sts.busy)
    `SIDT_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_accept, w_sts.busy)
    `SIDT_ASSERT_SAME(a_done_in_conv, i_clk, i_rst_n, w_sts.done, r_state == S_CONV)
    `SIDT_ASSERT_SAME(a_last_is_digit, i_clk, i_rst_n, r_tvalid && r_last, w_char_digit)

endmodule
